@@ sv/rlp_pkg.sv @@
// rlp_pkg: shared types and constants for the residency level policy block
// level and action codes, configuration register indexes, stream widths
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rlp_pkg;

  localparam int TIME_WIDTH_DEF = 32;
  localparam int NOW_W          = 32;
  localparam int DELAY_W        = 32;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int IN_DATA_W      = 40;
  localparam int OUT_DATA_W     = 16;

  typedef enum logic [1:0] {
    LVL_COLD = 2'd0,
    LVL_WARM = 2'd1,
    LVL_HOT  = 2'd2
  } level_t;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_PRELOAD = 2'd1,
    ACT_RELEASE = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRESSURE_TO_COLD = 3'd0,
    CFG_COLD_TO_WARM     = 3'd1,
    CFG_WARM_TO_HOT      = 3'd2,
    CFG_INTERACTION_HOLD = 3'd3,
    CFG_INITIAL_LEVEL    = 3'd4
  } cfg_idx_t;

endpackage

`default_nettype wire

@@ sv/residency_level_policy.sv @@
// residency_level_policy: background and effective residency level policy
// depends on rlp_pkg
//
// channel  dir  handshake                 payload
// s        in   s_tvalid / s_tready       s_tdata: event time and condition flags
// m        out  m_tvalid / m_tready       m_tdata: levels, action, status flags
// cfg      in   cfg_valid / cfg_ready     cfg_index, cfg_data
//
// one item per cycle sustained while m_tready is high; an item passes through the
// input register, then the result register, with all policy logic in between
// reset clears the timers, levels, configuration and both stage valids
// a stalled result holds in the result register while the input register can
// still take one more item; cfg_ready is always high
`timescale 1ns / 1ps
`default_nettype none

module residency_level_policy #(
  parameter int TIME_WIDTH = rlp_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // now_time[31:0], memory_pressure, fullscreen_active, energy_saver,
  // user_interaction, ui_visible, ui_pinned, resources_loaded, preload_allowed
  input  wire logic [rlp_pkg::IN_DATA_W-1:0]    s_tdata,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // prev_level[1:0], level[1:0], background_level[1:0], action[1:0],
  // level_changed, background_changed, pinned, release_deferred, zero pad
  output logic [rlp_pkg::OUT_DATA_W-1:0]        m_tdata,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [rlp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rlp_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rlp_pkg::*;

  localparam int TW = TIME_WIDTH;
  localparam int CW = (TW > DELAY_W) ? TW : DELAY_W;

  // configuration
  logic [DELAY_W-1:0] pressure_to_cold_delay;
  logic [DELAY_W-1:0] cold_to_warm_delay;
  logic [DELAY_W-1:0] warm_to_hot_delay;
  logic [DELAY_W-1:0] interaction_hold;
  logic [1:0]         initial_residency;

  // policy state
  logic          started;
  logic [TW-1:0] last_time;
  level_t        background_reg;
  level_t        effective_reg;
  logic          pressure_valid;
  logic [TW-1:0] pressure_start;
  logic          healthy_valid;
  logic [TW-1:0] healthy_start;
  logic          preload_valid;
  logic [TW-1:0] preload_start;
  logic          hold_valid;
  logic [TW-1:0] hold_deadline;

  // input register
  logic             in_valid;
  logic [NOW_W-1:0] in_now;
  logic             in_mem;
  logic             in_full;
  logic             in_saver;
  logic             in_inter;
  logic             in_vis;
  logic             in_pin;
  logic             in_loaded;
  logic             in_preload;

  // result register
  logic                  out_valid;
  logic [OUT_DATA_W-1:0] out_data;

  logic advance;
  logic in_take;

  // next state
  logic          started_next;
  level_t        background_next;
  level_t        effective_next;
  logic          pressure_valid_next;
  logic [TW-1:0] pressure_start_next;
  logic          healthy_valid_next;
  logic [TW-1:0] healthy_start_next;
  logic          preload_valid_next;
  logic [TW-1:0] preload_start_next;
  logic          hold_valid_next;
  logic [TW-1:0] hold_deadline_next;
  logic [OUT_DATA_W-1:0] out_data_next;

  function automatic logic elapsed(input logic [TW-1:0] now_t,
                                   input logic [TW-1:0] since,
                                   input logic [DELAY_W-1:0] delay);
    logic [TW-1:0] diff;
    diff = now_t - since;
    return (delay == '0) || (CW'(diff) >= CW'(delay));
  endfunction

  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign in_take   = s_tvalid && s_tready;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;
  assign cfg_ready = 1'b1;

  always_comb begin
    logic [TW-1:0] now_t;
    logic [TW-1:0] room;
    logic          press;
    logic          held;
    logic          pinned;
    logic          demand;
    level_t        init;
    level_t        bg;
    level_t        prev_bg;
    level_t        prev_eff;
    level_t        eff;
    action_t       act;

    now_t = TW'(in_now);
    press = in_mem || in_full || in_saver;
    init  = (initial_residency > 2'(LVL_HOT)) ? LVL_HOT : level_t'(initial_residency);

    started_next        = started;
    bg                  = background_reg;
    effective_next      = effective_reg;
    pressure_valid_next = pressure_valid;
    pressure_start_next = pressure_start;
    healthy_valid_next  = healthy_valid;
    healthy_start_next  = healthy_start;
    preload_valid_next  = preload_valid;
    preload_start_next  = preload_start;
    hold_valid_next     = hold_valid;
    hold_deadline_next  = hold_deadline;

    // first event or backward time step
    if (!started || (now_t < last_time)) begin
      if (!started) begin
        bg             = init;
        effective_next = init;
        started_next   = 1'b1;
      end else begin
        pressure_valid_next = 1'b0;
        healthy_valid_next  = 1'b0;
        preload_valid_next  = 1'b0;
        hold_valid_next     = 1'b0;
      end
      if (press) begin
        pressure_valid_next = 1'b1;
        pressure_start_next = now_t;
      end else begin
        healthy_valid_next = 1'b1;
        healthy_start_next = now_t;
      end
    end

    prev_bg  = bg;
    prev_eff = effective_next;

    // background level
    if (press) begin
      healthy_valid_next = 1'b0;
      preload_valid_next = 1'b0;
      if (!pressure_valid_next) begin
        pressure_valid_next = 1'b1;
        pressure_start_next = now_t;
      end
      if (in_mem || elapsed(now_t, pressure_start_next, pressure_to_cold_delay)) begin
        if (bg != LVL_COLD) begin
          bg                 = LVL_COLD;
          preload_valid_next = 1'b0;
        end
      end
    end else begin
      if (pressure_valid_next) begin
        pressure_valid_next = 1'b0;
        healthy_valid_next  = 1'b1;
        healthy_start_next  = now_t;
        preload_valid_next  = 1'b0;
      end else if (!healthy_valid_next) begin
        healthy_valid_next = 1'b1;
        healthy_start_next = now_t;
      end
      case (bg)
        LVL_COLD: begin
          if (elapsed(now_t, healthy_start_next, cold_to_warm_delay)) begin
            bg                 = LVL_WARM;
            preload_valid_next = 1'b0;
            if (in_preload) begin
              preload_valid_next = 1'b1;
              preload_start_next = now_t;
            end
          end
        end
        LVL_HOT: begin
          if (!in_preload && !in_loaded) begin
            bg                 = LVL_WARM;
            preload_valid_next = 1'b0;
          end
        end
        default: begin
          if (!in_preload) begin
            preload_valid_next = 1'b0;
          end else begin
            if (!preload_valid_next) begin
              preload_valid_next = 1'b1;
              preload_start_next = now_t;
            end
            if (elapsed(now_t, preload_start_next, warm_to_hot_delay)) begin
              bg                 = LVL_HOT;
              preload_valid_next = 1'b0;
            end
          end
        end
      endcase
    end
    background_next = bg;

    // interaction hold, deadline saturates at the top of the time range
    room = '1 - now_t;
    if (in_inter) begin
      hold_valid_next = 1'b1;
      if (CW'(interaction_hold) >= CW'(room)) begin
        hold_deadline_next = '1;
      end else begin
        hold_deadline_next = now_t + TW'(interaction_hold);
      end
    end
    held = in_inter || (hold_valid_next && (now_t < hold_deadline_next));
    if (!held) begin
      hold_valid_next = 1'b0;
    end

    pinned = in_vis || in_pin;
    demand = pinned || held;
    eff    = demand ? LVL_HOT : bg;
    effective_next = eff;

    act = ACT_NONE;
    if ((eff == LVL_HOT) && !in_loaded) begin
      if (demand || (in_preload && !press)) begin
        act = ACT_PRELOAD;
      end
    end else if ((eff != LVL_HOT) && in_loaded) begin
      act = ACT_RELEASE;
    end

    out_data_next = {4'b0000,
                     demand && (bg != LVL_HOT),
                     pinned,
                     bg != prev_bg,
                     eff != prev_eff,
                     act,
                     bg,
                     eff,
                     prev_eff};
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pressure_to_cold_delay <= '0;
      cold_to_warm_delay     <= '0;
      warm_to_hot_delay      <= '0;
      interaction_hold       <= '0;
      initial_residency      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PRESSURE_TO_COLD: pressure_to_cold_delay <= cfg_data;
        CFG_COLD_TO_WARM:     cold_to_warm_delay     <= cfg_data;
        CFG_WARM_TO_HOT:      warm_to_hot_delay      <= cfg_data;
        CFG_INTERACTION_HOLD: interaction_hold       <= cfg_data;
        CFG_INITIAL_LEVEL:    initial_residency      <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_take) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_now     <= s_tdata[NOW_W-1:0];
      in_mem     <= s_tdata[NOW_W];
      in_full    <= s_tdata[NOW_W+1];
      in_saver   <= s_tdata[NOW_W+2];
      in_inter   <= s_tdata[NOW_W+3];
      in_vis     <= s_tdata[NOW_W+4];
      in_pin     <= s_tdata[NOW_W+5];
      in_loaded  <= s_tdata[NOW_W+6];
      in_preload <= s_tdata[NOW_W+7];
    end
  end

  // policy state
  always_ff @(posedge clk) begin
    if (rst) begin
      started        <= 1'b0;
      last_time      <= '0;
      background_reg <= LVL_COLD;
      effective_reg  <= LVL_COLD;
      pressure_valid <= 1'b0;
      pressure_start <= '0;
      healthy_valid  <= 1'b0;
      healthy_start  <= '0;
      preload_valid  <= 1'b0;
      preload_start  <= '0;
      hold_valid     <= 1'b0;
      hold_deadline  <= '0;
    end else if (advance) begin
      started        <= started_next;
      last_time      <= TW'(in_now);
      background_reg <= background_next;
      effective_reg  <= effective_next;
      pressure_valid <= pressure_valid_next;
      pressure_start <= pressure_start_next;
      healthy_valid  <= healthy_valid_next;
      healthy_start  <= healthy_start_next;
      preload_valid  <= preload_valid_next;
      preload_start  <= preload_start_next;
      hold_valid     <= hold_valid_next;
      hold_deadline  <= hold_deadline_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= out_data_next;
    end
  end

  a_changed_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data[8] == (out_data[3:2] != out_data[1:0])))
    else $error("level_changed disagrees with levels");

  a_preload_hot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data[7:6] == ACT_PRELOAD)) |-> (out_data[3:2] == LVL_HOT))
    else $error("preload action without hot level");

  a_deferred: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data[11]) |->
      ((out_data[3:2] == LVL_HOT) && (out_data[5:4] != LVL_HOT)))
    else $error("release deferred with inconsistent levels");

  a_eff_tracks: assert property (@(posedge clk) disable iff (rst)
    advance |=> (started && (out_data[3:2] == effective_reg)
                 && (out_data[5:4] == background_reg)))
    else $error("stored levels differ from delivered levels");

endmodule

`default_nettype wire
